>>> hdl/wsgsa_pkg.sv
// shared types and constants of the wrapped subgrid gather / scatter-add block
package wsgsa_pkg;

  // fixed field widths
  localparam int CORNER_W    = 16;
  localparam int LOCAL_W     = 3;
  localparam int COIL_W      = 3;
  localparam int BASIS_W     = 2;
  localparam int SAMPLE_W    = 16;
  localparam int PART_W      = 32;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 64;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam int COUNT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COIL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_VCC    = 3'd4;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET       = 5'd16;
  localparam logic [COUNT_W-1:0]    COIL_COUNT_RESET = 4'd4;

  // wrap remainder unit: one magnitude bit per step
  localparam int MAG_W     = 16;
  localparam int DIV_STEPS = 16;
  localparam int STEP_W    = 4;

  // 1/sqrt2 in q1.15 and the matching right shift
  localparam logic signed [15:0] INV_SQRT2_Q15 = 16'sd23170;
  localparam int                 Q15_SHIFT     = 15;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_FIX,
    ST_ADDR,
    ST_READ,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic fix;
    logic addr;
    logic rd;
    logic mul;
    logic fin;
    logic clr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_scatter;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> hdl/wsgsa_ctrl.sv
// sequencing state machine: clearing pass, wrap steps, fold, address, read, scale, write back or output
module wsgsa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  wsgsa_pkg::dp_stat_t stat,
  output wsgsa_pkg::dp_cmd_t  cmd
);
  import wsgsa_pkg::*;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    step_next  = step;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // a gather waits for the output register to free up
        if (stat.is_scatter || !stat.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/wsgsa_dp.sv
// datapath: config registers, wrap remainder lanes, address, grid memory, scaling, output register
module wsgsa_dp #(
  parameter int GRID_DIM = 16,
  parameter int SUB_DIM  = 8,
  parameter int CHANNELS = 8,
  parameter int BASIS    = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wsgsa_pkg::dp_cmd_t                    cmd,
  output wsgsa_pkg::dp_stat_t                   stat,
  input  logic [wsgsa_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                  s_tuser,
  input  logic                                  cfg_valid,
  input  logic [wsgsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsgsa_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [wsgsa_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import wsgsa_pkg::*;

  localparam int DEPTH  = GRID_DIM * GRID_DIM * GRID_DIM * CHANNELS * BASIS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW     = $clog2(GRID_DIM + 1);
  localparam int OP_W   = PART_W + 1;
  localparam int PROD_W = OP_W + 16;
  localparam int SC_W   = PART_W + 2;
  localparam int SUM_W  = PART_W + 3;

  function automatic logic [NW-1:0] eff_size(input logic [CFG_DATA_W-1:0] s);
    if (s == '0) return NW'(1);
    if (32'(s) > GRID_DIM) return NW'(GRID_DIM);
    return NW'(s);
  endfunction

  function automatic logic [PART_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(64'sh7FFFFFFF)) return {1'b0, {(PART_W-1){1'b1}}};
    if (v < -SUM_W'(64'sh80000000)) return {1'b1, {(PART_W-1){1'b0}}};
    return v[PART_W-1:0];
  endfunction

  // configuration registers
  logic [CFG_DATA_W-1:0] size_x, size_y, size_z;
  logic [COUNT_W-1:0]    coil_count;
  logic                  has_vcc;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= SIZE_RESET;
      size_y     <= SIZE_RESET;
      size_z     <= SIZE_RESET;
      coil_count <= COIL_COUNT_RESET;
      has_vcc    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SIZE_X:     size_x     <= cfg_data;
        CFG_SIZE_Y:     size_y     <= cfg_data;
        CFG_SIZE_Z:     size_z     <= cfg_data;
        CFG_COIL_COUNT: coil_count <= cfg_data[COUNT_W-1:0];
        CFG_HAS_VCC:    has_vcc    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input beat fields
  logic signed [CORNER_W-1:0] in_corner [3];
  logic        [LOCAL_W-1:0]  in_local  [3];
  logic        [COIL_W-1:0]   in_coil;
  logic        [BASIS_W-1:0]  in_basis;
  logic                       in_vcc_half;
  logic signed [SAMPLE_W-1:0] in_re, in_im;

  assign in_corner[0] = s_tdata[15:0];
  assign in_corner[1] = s_tdata[31:16];
  assign in_corner[2] = s_tdata[47:32];
  assign in_local[0]  = s_tdata[50:48];
  assign in_local[1]  = s_tdata[53:51];
  assign in_local[2]  = s_tdata[56:54];
  assign in_coil      = s_tdata[59:57];
  assign in_basis     = s_tdata[61:60];
  assign in_vcc_half  = s_tdata[62];
  assign in_re        = s_tdata[78:63];
  assign in_im        = s_tdata[94:79];

  logic                 in_conj;
  logic [COIL_W+1:0]    in_ch;
  logic                 in_ok;
  logic [NW-1:0]        in_size [3];
  logic signed [CORNER_W:0] in_sum [3];

  always_comb begin
    in_conj    = has_vcc & in_vcc_half;
    in_ch      = (COIL_W+2)'(in_coil) + (in_conj ? (COIL_W+2)'(coil_count) : '0);
    in_ok      = ({1'b0, in_coil} < coil_count) && (32'(in_ch) < CHANNELS) &&
                 (32'(in_basis) < BASIS) && (32'(in_local[0]) < SUB_DIM) &&
                 (32'(in_local[1]) < SUB_DIM) && (32'(in_local[2]) < SUB_DIM);
    in_size[0] = eff_size(size_x);
    in_size[1] = eff_size(size_y);
    in_size[2] = eff_size(size_z);
    for (int i = 0; i < 3; i++) begin
      in_sum[i] = (CORNER_W+1)'(in_corner[i]) + $signed({1'b0, (CORNER_W)'(in_local[i])});
    end
  end

  // item registers
  logic                       action, conj, ok;
  logic [COIL_W+1:0]          ch;
  logic [BASIS_W-1:0]         basis;
  logic signed [SAMPLE_W-1:0] v_re, v_im;
  logic [MAG_W-1:0]           mag  [3];
  logic                       neg  [3];
  logic [NW-1:0]              nsz  [3];
  logic [NW-1:0]              rem  [3];
  logic [NW-1:0]              rem_next [3];
  logic [NW-1:0]              pos  [3];
  logic [NW:0]                trial [3];

  // one magnitude bit into each lane's remainder per step, then fold negative sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem[i], mag[i][MAG_W-1]};
      if (trial[i] >= {1'b0, nsz[i]}) rem_next[i] = NW'(trial[i] - {1'b0, nsz[i]});
      else rem_next[i] = trial[i][NW-1:0];
      pos[i] = (neg[i] && rem[i] != '0) ? NW'(nsz[i] - rem[i]) : rem[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= s_tuser;
      conj   <= in_conj;
      ok     <= in_ok;
      ch     <= in_ch;
      basis  <= in_basis;
      v_re   <= in_re;
      v_im   <= in_im;
      for (int i = 0; i < 3; i++) begin
        neg[i] <= in_sum[i][CORNER_W];
        mag[i] <= in_sum[i][CORNER_W] ? MAG_W'(-in_sum[i]) : MAG_W'(in_sum[i]);
        nsz[i] <= in_size[i];
        rem[i] <= '0;
      end
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        rem[i] <= rem_next[i];
        mag[i] <= {mag[i][MAG_W-2:0], 1'b0};
      end
    end else if (cmd.fix) begin
      for (int i = 0; i < 3; i++) rem[i] <= pos[i];
    end
  end

  // flat grid address
  logic [ADDR_W-1:0] addr;
  logic [31:0]       addr_full;

  always_comb begin
    addr_full = ((((32'(rem[2]) * GRID_DIM + 32'(rem[1])) * GRID_DIM + 32'(rem[0]))
                  * CHANNELS + 32'(ch)) * BASIS) + 32'(basis);
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) addr <= addr_full[ADDR_W-1:0];
  end

  // clearing pass counter
  logic [ADDR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
  end

  // grid memory, re in the low half
  logic [2*PART_W-1:0] mem [DEPTH];
  logic [2*PART_W-1:0] rdata;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [2*PART_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata <= mem[addr];
  end

  // scaling multipliers
  logic signed [OP_W-1:0]   op_re_next, op_im_next, op_im_raw;
  logic signed [OP_W-1:0]   op_re, op_im;
  logic signed [PROD_W-1:0] prod_re, prod_im;

  always_comb begin
    op_re_next = action ? OP_W'(v_re) : OP_W'($signed(rdata[PART_W-1:0]));
    op_im_raw  = action ? OP_W'(v_im) : OP_W'($signed(rdata[2*PART_W-1:PART_W]));
    op_im_next = conj ? -op_im_raw : op_im_raw;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      op_re   <= op_re_next;
      op_im   <= op_im_next;
      prod_re <= PROD_W'(op_re_next) * PROD_W'(INV_SQRT2_Q15);
      prod_im <= PROD_W'(op_im_next) * PROD_W'(INV_SQRT2_Q15);
    end
  end

  // round half up, then add or output
  logic signed [PROD_W-1:0] rnd_re, rnd_im;
  logic signed [SC_W-1:0]   sc_re, sc_im;
  logic signed [SUM_W-1:0]  sum_re, sum_im;

  always_comb begin
    rnd_re = (prod_re + PROD_W'(64'sd16384)) >>> Q15_SHIFT;
    rnd_im = (prod_im + PROD_W'(64'sd16384)) >>> Q15_SHIFT;
    sc_re  = has_vcc ? SC_W'(rnd_re) : SC_W'(op_re);
    sc_im  = has_vcc ? SC_W'(rnd_im) : SC_W'(op_im);
    sum_re = SUM_W'($signed(rdata[PART_W-1:0])) + SUM_W'(sc_re);
    sum_im = SUM_W'($signed(rdata[2*PART_W-1:PART_W])) + SUM_W'(sc_im);
    we     = cmd.clr || (cmd.fin && action && ok);
    waddr  = cmd.clr ? clr_cnt : addr;
    wdata  = cmd.clr ? '0 : {sat32(sum_im), sat32(sum_re)};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.fin && !action) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && !action) begin
      m_tdata <= ok ? {sc_im[PART_W-1:0], sc_re[PART_W-1:0]} : '0;
    end
  end

  assign stat.clr_done   = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign stat.is_scatter = action;
  assign stat.out_busy   = m_tvalid && !m_tready;

endmodule

>>> hdl/wrapped_subgrid_gather_scatter_add_top.sv
// top level of the wrapped subgrid gather / scatter-add block
// items are taken one at a time, only in idle, and no new one before the last is done: each
//   runs the 16-step wrap remainder unit plus the fold, address, memory read, multiply and
//   write-back or output steps; a gather may wait on the output
// reset: synchronous; the grid memory, GRID_DIM^3 * CHANNELS * BASIS entries (131072 at the
//   defaults), is then swept to zero, one entry a cycle, before any item is taken
module wrapped_subgrid_gather_scatter_add_top #(
  parameter int GRID_DIM = 16,
  parameter int SUB_DIM  = 8,
  parameter int CHANNELS = 8,
  parameter int BASIS    = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  // input item stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // corner_x, corner_y, corner_z (16 each), local_x, local_y, local_z (3 each), coil (3),
  // basis (2), vcc_half (1), value_re, value_im (16 each), one zero pad bit
  input  logic [wsgsa_pkg::IN_TDATA_W-1:0]   s_tdata,
  // action: 0 gather, 1 scatter-add
  input  logic                               s_tuser,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // read_re (32), read_im (32)
  output logic [wsgsa_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsgsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsgsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wsgsa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // controller: clearing pass, then one item at a time
  wsgsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: wrap lanes, grid memory, scaling and the output register
  wsgsa_dp #(
    .GRID_DIM (GRID_DIM),
    .SUB_DIM  (SUB_DIM),
    .CHANNELS (CHANNELS),
    .BASIS    (BASIS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // no input beat is taken while the grid is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clr |-> !s_tready)
    else $error("input taken during clearing pass");

  // a gather result only loads once the previous one has left
  a_fin_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin && !stat.is_scatter) |-> !stat.out_busy)
    else $error("result register overwritten");

  // a new result beat appears only right after a gather finishes
  a_out_from_gather: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.fin && !stat.is_scatter))
    else $error("result beat without a gather");

endmodule
